[rtl/core/ied_pkg.sv]
package ied_pkg;

  localparam int unsigned TYPE_W  = 5;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
  localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EV_REL = 5'd2;
  localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;

  localparam logic [CODE_W-1:0] SYN_REPORT         = 10'd0;
  localparam logic [CODE_W-1:0] CODE_CTRL_L        = 10'd29;
  localparam logic [CODE_W-1:0] CODE_SHIFT_L       = 10'd42;
  localparam logic [CODE_W-1:0] CODE_SHIFT_R       = 10'd54;
  localparam logic [CODE_W-1:0] CODE_CAPS_LOCK     = 10'd58;
  localparam logic [CODE_W-1:0] CODE_CTRL_R        = 10'd97;
  localparam logic [CODE_W-1:0] CODE_PTR_PRIMARY   = 10'd272;
  localparam logic [CODE_W-1:0] CODE_PTR_SECONDARY = 10'd273;
  localparam logic [CODE_W-1:0] CODE_PTR_MIDDLE    = 10'd274;
  localparam logic [CODE_W-1:0] CODE_PTR_TOUCH     = 10'd330;
  localparam logic [CODE_W-1:0] REL_X              = 10'd0;
  localparam logic [CODE_W-1:0] REL_Y              = 10'd1;
  localparam logic [CODE_W-1:0] REL_HSCROLL        = 10'd6;
  localparam logic [CODE_W-1:0] REL_WHEEL          = 10'd8;
  localparam logic [CODE_W-1:0] ABS_X              = 10'd0;
  localparam logic [CODE_W-1:0] ABS_Y              = 10'd1;

  localparam logic [2:0] BUTTON_LEFT       = 3'd1;
  localparam logic [2:0] BUTTON_MIDDLE     = 3'd2;
  localparam logic [2:0] BUTTON_RIGHT      = 3'd3;
  localparam logic [2:0] BUTTON_WHEEL_UP   = 3'd4;
  localparam logic [2:0] BUTTON_WHEEL_DOWN = 3'd5;
  localparam logic [2:0] BUTTON_HWHEEL_POS = 3'd6;
  localparam logic [2:0] BUTTON_HWHEEL_NEG = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_ABS_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MINIMUM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAXIMUM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MINIMUM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAXIMUM  = 3'd4;

  typedef enum logic [1:0] {
    RK_KEY    = 2'd0,
    RK_BUTTON = 2'd1,
    RK_REL    = 2'd2,
    RK_ABS    = 2'd3
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH_X,
    ST_WAIT_X,
    ST_LAUNCH_Y,
    ST_WAIT_Y,
    ST_EMIT
  } dec_state_e;

  typedef enum logic [2:0] {
    NP_IDLE,
    NP_CLAMP,
    NP_LOAD,
    NP_STEP,
    NP_DONE
  } norm_phase_e;

  typedef struct packed {
    logic                      start;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    logic signed [VALUE_W-1:0] value;
  } norm_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
  } norm_rsp_t;

  typedef struct packed {
    logic [1:0]                result_kind;
    logic [CODE_W-1:0]         key_code;
    logic [1:0]                key_state;
    logic                      shift_held;
    logic                      ctrl_held;
    logic                      caps_locked;
    logic [2:0]                button_number;
    logic signed [VALUE_W-1:0] button_level;
    logic signed [VALUE_W-1:0] move_x;
    logic signed [VALUE_W-1:0] move_y;
    logic [POS_W-1:0]          position_x;
    logic [POS_W-1:0]          position_y;
  } out_item_t;

endpackage

[rtl/core/ied_stream_if.sv]
interface ied_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ied_pkg::TYPE_W-1:0]             event_type;
  logic [ied_pkg::CODE_W-1:0]             event_code;
  logic signed [ied_pkg::VALUE_W-1:0]     event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink (input valid, event_type, event_code, event_value, output ready);
endinterface

interface ied_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         result_kind;
  logic [ied_pkg::CODE_W-1:0]         key_code;
  logic [1:0]                         key_state;
  logic                               shift_held;
  logic                               ctrl_held;
  logic                               caps_locked;
  logic [2:0]                         button_number;
  logic signed [ied_pkg::VALUE_W-1:0] button_level;
  logic signed [ied_pkg::VALUE_W-1:0] move_x;
  logic signed [ied_pkg::VALUE_W-1:0] move_y;
  logic [ied_pkg::POS_W-1:0]          position_x;
  logic [ied_pkg::POS_W-1:0]          position_y;

  modport source (output valid, result_kind, key_code, key_state, shift_held, ctrl_held,
                  caps_locked, button_number, button_level, move_x, move_y,
                  position_x, position_y, input ready);
  modport sink (input valid, result_kind, key_code, key_state, shift_held, ctrl_held,
                caps_locked, button_number, button_level, move_x, move_y,
                position_x, position_y, output ready);
endinterface

[rtl/core/ied_axis_norm.sv]
module ied_axis_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ied_pkg::norm_req_t req_i,
  output ied_pkg::norm_rsp_t rsp_o
);

  localparam int unsigned W  = ied_pkg::VALUE_W;
  localparam int unsigned PW = ied_pkg::POS_W;
  localparam int unsigned CW = $clog2(PW);

  ied_pkg::norm_phase_e phase_q, phase_d;

  logic signed [W-1:0] lo_q, hi_q, val_q;
  logic [W-1:0]        diff_q, den_q, rem_q;
  logic [PW-1:0]       quo_q;
  logic                empty_q;
  logic [CW-1:0]       cnt_q;

  logic signed [W-1:0] clamped;
  logic [W:0]          diff_ext, den_ext, trial;
  logic [W+PW-1:0]     scaled;
  logic                borrow;

  // Clamp the stored value into the axis range and form both differences.
  always_comb begin
    if (val_q < lo_q) begin
      clamped = lo_q;
    end else if (val_q > hi_q) begin
      clamped = hi_q;
    end else begin
      clamped = val_q;
    end
    diff_ext = {clamped[W-1], clamped} - {lo_q[W-1], lo_q};
    den_ext  = {hi_q[W-1], hi_q} - {lo_q[W-1], lo_q};
  end

  // Multiplication by 65535 is a shift and one subtraction.
  assign scaled = {diff_q, {PW{1'b0}}} - {{PW{1'b0}}, diff_q};

  // One restoring division step: the quotient fits in the low half, so the
  // upper half of the scaled numerator is already below the divisor.
  assign trial  = {rem_q, quo_q[PW-1]} - {1'b0, den_q};
  assign borrow = trial[W];

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      ied_pkg::NP_IDLE: begin
        if (req_i.start) begin
          phase_d = ied_pkg::NP_CLAMP;
        end
      end
      ied_pkg::NP_CLAMP: phase_d = ied_pkg::NP_LOAD;
      ied_pkg::NP_LOAD:  phase_d = ied_pkg::NP_STEP;
      ied_pkg::NP_STEP: begin
        if (cnt_q == CW'(PW - 1)) begin
          phase_d = ied_pkg::NP_DONE;
        end
      end
      ied_pkg::NP_DONE:  phase_d = ied_pkg::NP_IDLE;
      default:           phase_d = ied_pkg::NP_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (phase_q == ied_pkg::NP_DONE);
    rsp_o.pos  = empty_q ? '0 : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ied_pkg::NP_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == ied_pkg::NP_STEP) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      ied_pkg::NP_IDLE: begin
        if (req_i.start) begin
          lo_q  <= req_i.lo;
          hi_q  <= req_i.hi;
          val_q <= req_i.value;
        end
      end
      ied_pkg::NP_CLAMP: begin
        empty_q <= (hi_q <= lo_q);
        diff_q  <= diff_ext[W-1:0];
        den_q   <= den_ext[W-1:0];
      end
      ied_pkg::NP_LOAD: begin
        rem_q <= scaled[W+PW-1:PW];
        quo_q <= scaled[PW-1:0];
      end
      ied_pkg::NP_STEP: begin
        if (borrow) begin
          rem_q <= {rem_q[W-2:0], quo_q[PW-1]};
        end else begin
          rem_q <= trial[W-1:0];
        end
        quo_q <= {quo_q[PW-2:0], ~borrow};
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/input_event_decoder_core.sv]
// Channel  Direction  Carries
// in_i     sink       event_type, event_code, event_value
// out_o    source     one decoded result per request that yields one
// cfg      write      absolute_enable, x/y minimum and maximum by index
//
// Key, button and relative requests are decoded in the cycle they are accepted.
// A sync report with a pending position stalls the input: each axis takes a launch
// state, then clamp, scale, 16 restoring divide steps and hand-back in the one shared
// unit, and an emit state presents the result once the output register is free. The
// next request can be accepted after the emit state has loaded the result.
// Reset clears the flags, the stored position and all configuration registers.
// The input stalls while a position is normalised or the output register is full.
module input_event_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ied_in_if.sink                              in_i,
  ied_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [ied_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ied_pkg::VALUE_W-1:0]         cfg_wdata_i
);

  localparam int unsigned W = ied_pkg::VALUE_W;

  ied_pkg::dec_state_e state_q, state_d;

  logic                abs_en_q;
  logic signed [W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic                shift_q, shift_d, ctrl_q, ctrl_d, caps_q, caps_d;
  logic                dirty_q, dirty_d;
  logic signed [W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [ied_pkg::POS_W-1:0] pos_x_q;

  logic                out_valid_q;
  ied_pkg::out_item_t  out_q, res;
  logic                res_valid, sync_start;
  logic                accept, out_free, key_ok, wheel_pos, emit_load;

  ied_pkg::norm_req_t  norm_req;
  ied_pkg::norm_rsp_t  norm_rsp;

  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign key_ok   = !in_i.event_value[W-1] && (in_i.event_value[W-2:0] <= (W-1)'(2));
  assign wheel_pos = !in_i.event_value[W-1] && (in_i.event_value != '0);

  ied_axis_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .rsp_o  (norm_rsp)
  );

  always_comb begin
    res_valid  = 1'b0;
    sync_start = 1'b0;
    res        = '0;
    shift_d    = shift_q;
    ctrl_d     = ctrl_q;
    caps_d     = caps_q;
    dirty_d    = dirty_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    if (accept) begin
      case (in_i.event_type)
        ied_pkg::EV_KEY: begin
          if (in_i.event_code == ied_pkg::CODE_PTR_PRIMARY ||
              in_i.event_code == ied_pkg::CODE_PTR_TOUCH) begin
            res_valid         = 1'b1;
            res.result_kind   = ied_pkg::RK_BUTTON;
            res.button_number = ied_pkg::BUTTON_LEFT;
            res.button_level  = in_i.event_value;
          end else if (in_i.event_code == ied_pkg::CODE_PTR_MIDDLE) begin
            res_valid         = 1'b1;
            res.result_kind   = ied_pkg::RK_BUTTON;
            res.button_number = ied_pkg::BUTTON_MIDDLE;
            res.button_level  = in_i.event_value;
          end else if (in_i.event_code == ied_pkg::CODE_PTR_SECONDARY) begin
            res_valid         = 1'b1;
            res.result_kind   = ied_pkg::RK_BUTTON;
            res.button_number = ied_pkg::BUTTON_RIGHT;
            res.button_level  = in_i.event_value;
          end else if (!key_ok) begin
          end else if (in_i.event_code == ied_pkg::CODE_SHIFT_L ||
                       in_i.event_code == ied_pkg::CODE_SHIFT_R) begin
            shift_d = (in_i.event_value[1:0] != 2'd0);
          end else if (in_i.event_code == ied_pkg::CODE_CTRL_L ||
                       in_i.event_code == ied_pkg::CODE_CTRL_R) begin
            ctrl_d = (in_i.event_value[1:0] != 2'd0);
          end else if (in_i.event_code == ied_pkg::CODE_CAPS_LOCK) begin
            if (in_i.event_value[1:0] == 2'd1) begin
              caps_d = ~caps_q;
            end
          end else begin
            res_valid       = 1'b1;
            res.result_kind = ied_pkg::RK_KEY;
            res.key_code    = in_i.event_code;
            res.key_state   = in_i.event_value[1:0];
            res.shift_held  = shift_q;
            res.ctrl_held   = ctrl_q;
            res.caps_locked = caps_q;
          end
        end
        ied_pkg::EV_REL: begin
          if (in_i.event_code == ied_pkg::REL_X) begin
            res_valid       = 1'b1;
            res.result_kind = ied_pkg::RK_REL;
            res.move_x      = in_i.event_value;
          end else if (in_i.event_code == ied_pkg::REL_Y) begin
            res_valid       = 1'b1;
            res.result_kind = ied_pkg::RK_REL;
            res.move_y      = in_i.event_value;
          end else if (in_i.event_code == ied_pkg::REL_WHEEL) begin
            res_valid         = 1'b1;
            res.result_kind   = ied_pkg::RK_BUTTON;
            res.button_number = wheel_pos ? ied_pkg::BUTTON_WHEEL_UP
                                          : ied_pkg::BUTTON_WHEEL_DOWN;
            res.button_level  = W'(1);
          end else if (in_i.event_code == ied_pkg::REL_HSCROLL) begin
            res_valid         = 1'b1;
            res.result_kind   = ied_pkg::RK_BUTTON;
            res.button_number = wheel_pos ? ied_pkg::BUTTON_HWHEEL_POS
                                          : ied_pkg::BUTTON_HWHEEL_NEG;
            res.button_level  = W'(1);
          end
        end
        ied_pkg::EV_ABS: begin
          if (abs_en_q && in_i.event_code == ied_pkg::ABS_X) begin
            cur_x_d = in_i.event_value;
            dirty_d = 1'b1;
          end else if (abs_en_q && in_i.event_code == ied_pkg::ABS_Y) begin
            cur_y_d = in_i.event_value;
            dirty_d = 1'b1;
          end
        end
        ied_pkg::EV_SYN: begin
          if (in_i.event_code == ied_pkg::SYN_REPORT && dirty_q) begin
            sync_start = 1'b1;
            dirty_d    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ied_pkg::ST_IDLE: begin
        if (sync_start) begin
          state_d = ied_pkg::ST_LAUNCH_X;
        end
      end
      ied_pkg::ST_LAUNCH_X: state_d = ied_pkg::ST_WAIT_X;
      ied_pkg::ST_WAIT_X: begin
        if (norm_rsp.done) begin
          state_d = ied_pkg::ST_LAUNCH_Y;
        end
      end
      ied_pkg::ST_LAUNCH_Y: state_d = ied_pkg::ST_WAIT_Y;
      ied_pkg::ST_WAIT_Y: begin
        if (norm_rsp.done) begin
          state_d = ied_pkg::ST_EMIT;
        end
      end
      ied_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = ied_pkg::ST_IDLE;
        end
      end
      default: state_d = ied_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready     = (state_q == ied_pkg::ST_IDLE) && out_free;
    emit_load      = (state_q == ied_pkg::ST_EMIT) && out_free;
    norm_req.start = (state_q == ied_pkg::ST_LAUNCH_X) || (state_q == ied_pkg::ST_LAUNCH_Y);
    if (state_q == ied_pkg::ST_LAUNCH_Y) begin
      norm_req.lo    = y_min_q;
      norm_req.hi    = y_max_q;
      norm_req.value = cur_y_q;
    end else begin
      norm_req.lo    = x_min_q;
      norm_req.hi    = x_max_q;
      norm_req.value = cur_x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ied_pkg::ST_IDLE;
      abs_en_q    <= 1'b0;
      x_min_q     <= '0;
      x_max_q     <= '0;
      y_min_q     <= '0;
      y_max_q     <= '0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      caps_q      <= 1'b0;
      dirty_q     <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      caps_q  <= caps_d;
      dirty_q <= dirty_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      if (res_valid || emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ied_pkg::CFG_ABS_ENABLE: abs_en_q <= cfg_wdata_i[0];
          ied_pkg::CFG_X_MINIMUM:  x_min_q  <= cfg_wdata_i;
          ied_pkg::CFG_X_MAXIMUM:  x_max_q  <= cfg_wdata_i;
          ied_pkg::CFG_Y_MINIMUM:  y_min_q  <= cfg_wdata_i;
          ied_pkg::CFG_Y_MAXIMUM:  y_max_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ied_pkg::ST_WAIT_X && norm_rsp.done) begin
      pos_x_q <= norm_rsp.pos;
    end
    if (res_valid) begin
      out_q <= res;
    end else if (state_q == ied_pkg::ST_WAIT_Y && norm_rsp.done) begin
      out_q             <= '0;
      out_q.result_kind <= ied_pkg::RK_ABS;
      out_q.position_x  <= pos_x_q;
      out_q.position_y  <= norm_rsp.pos;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = out_q.result_kind;
  assign out_o.key_code      = out_q.key_code;
  assign out_o.key_state     = out_q.key_state;
  assign out_o.shift_held    = out_q.shift_held;
  assign out_o.ctrl_held     = out_q.ctrl_held;
  assign out_o.caps_locked   = out_q.caps_locked;
  assign out_o.button_number = out_q.button_number;
  assign out_o.button_level  = out_q.button_level;
  assign out_o.move_x        = out_q.move_x;
  assign out_o.move_y        = out_q.move_y;
  assign out_o.position_x    = out_q.position_x;
  assign out_o.position_y    = out_q.position_y;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_rsp.done |-> (state_q == ied_pkg::ST_WAIT_X || state_q == ied_pkg::ST_WAIT_Y))
    else $error("Normaliser finished outside a wait state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_start |=> (state_q == ied_pkg::ST_LAUNCH_X && !dirty_q))
    else $error("Sync report did not launch normalisation.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (out_valid_q && out_q.result_kind == ied_pkg::RK_ABS))
    else $error("Absolute position result was not presented.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ied_pkg::ST_IDLE) |-> !res_valid)
    else $error("Request decoded while a position is being normalised.");

endmodule

[tb/testbench.sv]
module testbench;

  typedef logic [ied_pkg::TYPE_W-1:0] evtype_t;
  typedef logic [ied_pkg::CODE_W-1:0] code_t;
  typedef logic [ied_pkg::POS_W-1:0]  pos_t;

  typedef struct packed {
    evtype_t                            etype;
    code_t                              ecode;
    logic signed [ied_pkg::VALUE_W-1:0] evalue;
  } ev_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [ied_pkg::CFG_IDX_W-1:0] cfg_idx_i = ied_pkg::CFG_ABS_ENABLE;
  logic [ied_pkg::VALUE_W-1:0]   cfg_wdata_i = '0;

  ied_in_if  in_ch ();
  ied_out_if out_ch ();

  input_event_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Configuration and decoder state as the block should hold them.
  logic                               abs_on;
  logic signed [ied_pkg::VALUE_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic                               shift_on, ctrl_on, caps_on, pos_dirty;
  logic signed [ied_pkg::VALUE_W-1:0] pos_x, pos_y;

  ev_t                event_queue[$];
  ied_pkg::out_item_t pending_results[$];
  ev_t                cur_event;
  int                 events_queued = 0;
  int                 events_accepted = 0;
  int                 fail_count = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  logic [7:0]         stall_pattern = 8'h00;
  int                 pattern_age = 0;

  function automatic pos_t scale_axis(input longint lo, input longint hi, input longint v);
    longint c;
    if (hi <= lo) return '0;
    c = (v < lo) ? lo : ((v > hi) ? hi : v);
    return pos_t'(((c - lo) * 65535) / (hi - lo));
  endfunction

  function automatic bit decode_event(input ev_t e, output ied_pkg::out_item_t r);
    r = '0;
    case (e.etype)
      ied_pkg::EV_KEY: begin
        if (e.ecode == ied_pkg::CODE_PTR_PRIMARY || e.ecode == ied_pkg::CODE_PTR_TOUCH ||
            e.ecode == ied_pkg::CODE_PTR_MIDDLE || e.ecode == ied_pkg::CODE_PTR_SECONDARY) begin
          r.result_kind   = ied_pkg::RK_BUTTON;
          r.button_number = (e.ecode == ied_pkg::CODE_PTR_MIDDLE) ? ied_pkg::BUTTON_MIDDLE :
                            (e.ecode == ied_pkg::CODE_PTR_SECONDARY) ? ied_pkg::BUTTON_RIGHT :
                            ied_pkg::BUTTON_LEFT;
          r.button_level  = e.evalue;
          return 1'b1;
        end
        if ($signed(e.evalue) < 0 || $signed(e.evalue) > 2) return 1'b0;
        if (e.ecode == ied_pkg::CODE_SHIFT_L || e.ecode == ied_pkg::CODE_SHIFT_R) begin
          shift_on = (e.evalue != 0);
          return 1'b0;
        end
        if (e.ecode == ied_pkg::CODE_CTRL_L || e.ecode == ied_pkg::CODE_CTRL_R) begin
          ctrl_on = (e.evalue != 0);
          return 1'b0;
        end
        if (e.ecode == ied_pkg::CODE_CAPS_LOCK) begin
          if (e.evalue == 1) caps_on = !caps_on;
          return 1'b0;
        end
        r.result_kind = ied_pkg::RK_KEY;
        r.key_code    = e.ecode;
        r.key_state   = e.evalue[1:0];
        r.shift_held  = shift_on;
        r.ctrl_held   = ctrl_on;
        r.caps_locked = caps_on;
        return 1'b1;
      end
      ied_pkg::EV_REL: begin
        r.result_kind = ied_pkg::RK_REL;
        if (e.ecode == ied_pkg::REL_X) begin
          r.move_x = e.evalue;
          return 1'b1;
        end
        if (e.ecode == ied_pkg::REL_Y) begin
          r.move_y = e.evalue;
          return 1'b1;
        end
        r.result_kind  = ied_pkg::RK_BUTTON;
        r.button_level = 1;
        if (e.ecode == ied_pkg::REL_WHEEL) begin
          r.button_number = ($signed(e.evalue) > 0) ? ied_pkg::BUTTON_WHEEL_UP
                                                    : ied_pkg::BUTTON_WHEEL_DOWN;
          return 1'b1;
        end
        if (e.ecode == ied_pkg::REL_HSCROLL) begin
          r.button_number = ($signed(e.evalue) > 0) ? ied_pkg::BUTTON_HWHEEL_POS
                                                    : ied_pkg::BUTTON_HWHEEL_NEG;
          return 1'b1;
        end
        r = '0;
        return 1'b0;
      end
      ied_pkg::EV_ABS: begin
        if (abs_on && (e.ecode == ied_pkg::ABS_X || e.ecode == ied_pkg::ABS_Y)) begin
          if (e.ecode == ied_pkg::ABS_Y) pos_y = e.evalue;
          else pos_x = e.evalue;
          pos_dirty = 1'b1;
        end
        return 1'b0;
      end
      ied_pkg::EV_SYN: begin
        if (e.ecode == ied_pkg::SYN_REPORT && pos_dirty) begin
          pos_dirty     = 1'b0;
          r.result_kind = ied_pkg::RK_ABS;
          r.position_x  = scale_axis(x_lo, x_hi, pos_x);
          r.position_y  = scale_axis(y_lo, y_hi, pos_y);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    ied_pkg::out_item_t res;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (decode_event(cur_event, res)) pending_results.push_back(res);
        events_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0 || event_queue.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          cur_event = event_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.event_type  <= cur_event.etype;
          in_ch.event_code  <= cur_event.ecode;
          in_ch.event_value <= cur_event.evalue;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ied_pkg::out_item_t got;
    ied_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind   = out_ch.result_kind;
        got.key_code      = out_ch.key_code;
        got.key_state     = out_ch.key_state;
        got.shift_held    = out_ch.shift_held;
        got.ctrl_held     = out_ch.ctrl_held;
        got.caps_locked   = out_ch.caps_locked;
        got.button_number = out_ch.button_number;
        got.button_level  = out_ch.button_level;
        got.move_x        = out_ch.move_x;
        got.move_y        = out_ch.move_y;
        got.position_x    = out_ch.position_x;
        got.position_y    = out_ch.position_y;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("result_kind", want.result_kind, got.result_kind);
          compare_field("key_code", want.key_code, got.key_code);
          compare_field("key_state", want.key_state, got.key_state);
          compare_field("shift_held", want.shift_held, got.shift_held);
          compare_field("ctrl_held", want.ctrl_held, got.ctrl_held);
          compare_field("caps_locked", want.caps_locked, got.caps_locked);
          compare_field("button_number", want.button_number, got.button_number);
          compare_field("button_level", want.button_level, got.button_level);
          compare_field("move_x", want.move_x, got.move_x);
          compare_field("move_y", want.move_y, got.move_y);
          compare_field("position_x", want.position_x, got.position_x);
          compare_field("position_y", want.position_y, got.position_y);
        end
      end
      pattern_age++;
      if (pattern_age >= 64) begin
        pattern_age   = 0;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      end
      out_ch.ready  <= !stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
    end
  end

  task automatic queue_event(input evtype_t t, input code_t c,
                             input logic [ied_pkg::VALUE_W-1:0] v);
    ev_t e;
    e.etype  = t;
    e.ecode  = c;
    e.evalue = v;
    event_queue.push_back(e);
    events_queued++;
  endtask

  task automatic write_reg(input logic [ied_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ied_pkg::VALUE_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      ied_pkg::CFG_ABS_ENABLE: abs_on = data[0];
      ied_pkg::CFG_X_MINIMUM:  x_lo = data;
      ied_pkg::CFG_X_MAXIMUM:  x_hi = data;
      ied_pkg::CFG_Y_MINIMUM:  y_lo = data;
      ied_pkg::CFG_Y_MAXIMUM:  y_hi = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic en, input logic [31:0] xl, input logic [31:0] xh,
                           input logic [31:0] yl, input logic [31:0] yh);
    write_reg(ied_pkg::CFG_ABS_ENABLE, {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, en});
    write_reg(ied_pkg::CFG_X_MINIMUM, xl);
    write_reg(ied_pkg::CFG_X_MAXIMUM, xh);
    write_reg(ied_pkg::CFG_Y_MINIMUM, yl);
    write_reg(ied_pkg::CFG_Y_MAXIMUM, yh);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (events_accepted != events_queued || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_axis(input longint lo, input longint hi);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'(lo);
      2: return 32'(hi);
      default: begin
        if (hi > lo) return 32'(lo + (longint'({$urandom, $urandom} >> 1) % (hi - lo + 1)));
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [31:0] key_value();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 2);
    return $urandom;
  endfunction

  task automatic queue_random_event();
    code_t c;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      case ($urandom_range(0, 9))
        0: c = $urandom_range(0, 1) ? ied_pkg::CODE_SHIFT_L : ied_pkg::CODE_SHIFT_R;
        1: c = $urandom_range(0, 1) ? ied_pkg::CODE_CTRL_L : ied_pkg::CODE_CTRL_R;
        2: c = ied_pkg::CODE_CAPS_LOCK;
        3: begin
          case ($urandom_range(0, 3))
            0: c = ied_pkg::CODE_PTR_PRIMARY;
            1: c = ied_pkg::CODE_PTR_SECONDARY;
            2: c = ied_pkg::CODE_PTR_MIDDLE;
            default: c = ied_pkg::CODE_PTR_TOUCH;
          endcase
        end
        default: c = code_t'($urandom_range(0, 767));
      endcase
      queue_event(ied_pkg::EV_KEY, c, key_value());
    end else if (sel < 50) begin
      case ($urandom_range(0, 9))
        0, 1: c = ied_pkg::REL_X;
        2, 3: c = ied_pkg::REL_Y;
        4, 5: c = ied_pkg::REL_WHEEL;
        6, 7: c = ied_pkg::REL_HSCROLL;
        default: c = code_t'($urandom_range(0, 767));
      endcase
      queue_event(ied_pkg::EV_REL, c, $urandom_range(0, 2) == 0 ? 32'($urandom) :
                  32'($signed($urandom_range(0, 40)) - 20));
    end else if (sel < 75) begin
      c = ($urandom_range(0, 9) == 0) ? code_t'($urandom_range(0, 767)) :
          ($urandom_range(0, 1) ? ied_pkg::ABS_Y : ied_pkg::ABS_X);
      queue_event(ied_pkg::EV_ABS, c,
                  (c == ied_pkg::ABS_Y) ? pick_axis(y_lo, y_hi) : pick_axis(x_lo, x_hi));
    end else if (sel < 90) begin
      c = ($urandom_range(0, 9) == 0) ? code_t'($urandom_range(0, 767)) : ied_pkg::SYN_REPORT;
      queue_event(ied_pkg::EV_SYN, c, $urandom_range(0, 1) ? 32'($urandom) : 32'd0);
    end else begin
      queue_event(evtype_t'($urandom_range(0, 31)), code_t'($urandom_range(0, 767)), $urandom);
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.event_type  = ied_pkg::EV_SYN;
    in_ch.event_code  = ied_pkg::SYN_REPORT;
    in_ch.event_value = '0;
    out_ch.ready      = 1'b0;
    abs_on    = 1'b0;
    x_lo      = '0;
    x_hi      = '0;
    y_lo      = '0;
    y_hi      = '0;
    shift_on  = 1'b0;
    ctrl_on   = 1'b0;
    caps_on   = 1'b0;
    pos_dirty = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_SHIFT_L, 32'd1);
    queue_event(ied_pkg::EV_KEY, 10'd30, 32'd1);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_CTRL_R, 32'd2);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_CAPS_LOCK, 32'd1);
    queue_event(ied_pkg::EV_KEY, 10'd767, 32'd2);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_CAPS_LOCK, 32'd2);
    queue_event(ied_pkg::EV_KEY, 10'd0, 32'd0);
    queue_event(ied_pkg::EV_KEY, 10'd30, 32'd3);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_SHIFT_L, 32'hFFFF_FFFF);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_PTR_PRIMARY, 32'h7FFF_FFFF);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_PTR_TOUCH, 32'h8000_0000);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_PTR_MIDDLE, 32'd1);
    queue_event(ied_pkg::EV_KEY, ied_pkg::CODE_PTR_SECONDARY, 32'd0);
    queue_event(ied_pkg::EV_REL, ied_pkg::REL_X, 32'h8000_0000);
    queue_event(ied_pkg::EV_REL, ied_pkg::REL_Y, 32'h7FFF_FFFF);
    queue_event(ied_pkg::EV_REL, ied_pkg::REL_WHEEL, 32'd0);
    queue_event(ied_pkg::EV_REL, ied_pkg::REL_WHEEL, 32'd1);
    queue_event(ied_pkg::EV_REL, ied_pkg::REL_HSCROLL, 32'hFFFF_FFFF);
    queue_event(ied_pkg::EV_REL, ied_pkg::REL_HSCROLL, 32'd5);
    queue_event(ied_pkg::EV_REL, 10'd2, 32'd9);
    queue_event(ied_pkg::EV_ABS, ied_pkg::ABS_X, 32'd100);
    queue_event(ied_pkg::EV_SYN, ied_pkg::SYN_REPORT, 32'd0);
    queue_event(5'd31, 10'd767, 32'hFFFF_FFFF);
    wait_idle();

    configure(1'b1, -32'sd100, 32'sd100, 32'd0, 32'd0);
    queue_event(ied_pkg::EV_ABS, ied_pkg::ABS_X, -32'sd500);
    queue_event(ied_pkg::EV_ABS, ied_pkg::ABS_Y, 32'd7);
    queue_event(ied_pkg::EV_SYN, ied_pkg::SYN_REPORT, 32'd0);
    queue_event(ied_pkg::EV_ABS, ied_pkg::ABS_X, 32'd500);
    queue_event(ied_pkg::EV_SYN, 10'd1, 32'd0);
    queue_event(ied_pkg::EV_SYN, ied_pkg::SYN_REPORT, 32'd0);
    queue_event(ied_pkg::EV_SYN, ied_pkg::SYN_REPORT, 32'd0);
    queue_event(ied_pkg::EV_ABS, 10'd2, 32'd5);
    queue_event(ied_pkg::EV_SYN, ied_pkg::SYN_REPORT, 32'd0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        1: configure(1'b1, 32'd0, 32'd1919, 32'd0, 32'd1079);
        2: configure(1'b0, $urandom, $urandom, $urandom, $urandom);
        3: configure(1'b1, 32'd5, 32'd5, -32'sd7, -32'sd8);
        4: configure(1'b1, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001);
        default: configure(1'b1, $urandom, $urandom, $urandom, $urandom);
      endcase
      repeat (150) queue_random_event();
      wait_idle();
    end

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
